// ===== rtl/core/numeric_option_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Numeric option parser assertion macros
// Shared wrappers for the concurrent checks of the parser.
// ----------------------------------------------------------------------------
`ifndef NUMERIC_OPTION_PARSER_MACROS_SVH
`define NUMERIC_OPTION_PARSER_MACROS_SVH

// same-cycle implication
`define NOP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("numeric_option_parser: check failed");

// next-cycle implication
`define NOP_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("numeric_option_parser: check failed");

`endif

// ===== rtl/core/nop_pkg.sv =====
// ----------------------------------------------------------------------------
// Numeric option parser package
// Character codes, radix select codes, lane control word and char helpers.
// ----------------------------------------------------------------------------
package nop_pkg;

	// radix select: index of the accumulator lane
	typedef enum logic [1:0] {
		SEL_BIN = 2'd0,
		SEL_OCT = 2'd1,
		SEL_DEC = 2'd2,
		SEL_HEX = 2'd3
	} radix_sel_t;

	localparam int NUM_LANES = 4;

	// digit code for a character that is no digit in any radix
	localparam logic [5:0] DIGIT_BAD = 6'd63;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5a;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7a;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LO    = 8'h6f;
	localparam logic [7:0] CH_LQ    = 8'h71;
	localparam logic [7:0] CH_LD    = 8'h64;
	localparam logic [7:0] CH_LH    = 8'h68;
	localparam logic [7:0] CASE_BIT = 8'h20;

	// control word from the parser to each accumulator lane
	typedef struct packed {
		logic       adv;     // the item in the input stage is consumed
		logic       clr;     // end of string: back to reset values
		logic       sr;      // signed range limit
		logic       feed_a;  // first digit of this cycle
		logic [5:0] dig_a;
		logic       feed_b;  // second digit (word closed by the last char)
		logic [5:0] dig_b;
	} lane_ctrl_t;

	// suffix decode result
	typedef struct packed {
		logic       hit;
		radix_sel_t sel;
	} sfx_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [5:0] digit_val(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d = c - CH_UA + 8'd10;
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d = c - CH_LA + 8'd10;
		end else begin
			d = {2'b00, DIGIT_BAD};
		end
		return d[5:0];
	endfunction

	function automatic sfx_t sfx_decode(input logic [7:0] c);
		logic [7:0] u;
		sfx_t       s;
		u = c | CASE_BIT;
		s.hit = 1'b1;
		s.sel = SEL_DEC;
		if (u == CH_LB) begin
			s.sel = SEL_BIN;
		end else if (u == CH_LO || u == CH_LQ) begin
			s.sel = SEL_OCT;
		end else if (u == CH_LD) begin
			s.sel = SEL_DEC;
		end else if (u == CH_LH) begin
			s.sel = SEL_HEX;
		end else begin
			s.hit = 1'b0;
		end
		return s;
	endfunction

endpackage

// ===== rtl/core/nop_in_if.sv =====
// ----------------------------------------------------------------------------
// Numeric option parser input channel
// One character word per handshake, last character marked.
// ----------------------------------------------------------------------------
interface nop_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       is_last;

	modport source (output valid, char_in, is_last, input ready);
	modport sink (input valid, char_in, is_last, output ready);
endinterface

// ===== rtl/core/nop_out_if.sv =====
// ----------------------------------------------------------------------------
// Numeric option parser result channel
// One result word per parsed string: value, fail flag and error index.
// ----------------------------------------------------------------------------
interface nop_out_if #(
	parameter int WORD_BITS = 16,
	parameter int POS_BITS  = 8
);
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] value;
	logic                 failed;
	logic [POS_BITS-1:0]  error_pos;

	modport source (output valid, value, failed, error_pos, input ready);
	modport sink (input valid, value, failed, error_pos, output ready);
endinterface

// ===== rtl/core/nop_lane.sv =====
// ----------------------------------------------------------------------------
// Numeric option parser accumulator lane
// One fixed-radix accumulator with overflow / bad digit stop and position.
// ----------------------------------------------------------------------------
module nop_lane #(
	parameter int                  WORD_BITS = 16,
	parameter int                  POS_BITS  = 8,
	parameter nop_pkg::radix_sel_t SEL       = nop_pkg::SEL_DEC
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nop_pkg::lane_ctrl_t  ctrl,
	input  logic [POS_BITS-1:0]  pos_a,
	input  logic [POS_BITS-1:0]  pos_b,
	output logic [WORD_BITS-1:0] acc_nx,
	output logic                 stop_nx,
	output logic [POS_BITS-1:0]  spos_nx
);

	// product width: n * 16 + 15 fits
	localparam int XW = WORD_BITS + 4;
	localparam logic [XW-1:0] UMAX_X = {4'b0000, {WORD_BITS{1'b1}}};
	localparam logic [XW-1:0] SMAX_X = UMAX_X >> 1;
	localparam logic [5:0] RADIX =
		(SEL == nop_pkg::SEL_BIN) ? 6'd2 :
		(SEL == nop_pkg::SEL_OCT) ? 6'd8 :
		(SEL == nop_pkg::SEL_DEC) ? 6'd10 : 6'd16;

	logic [WORD_BITS-1:0] acc_q;
	logic                 stop_q;
	logic [POS_BITS-1:0]  spos_q;

	// n * radix + d, from shifts and adds
	function automatic logic [XW-1:0] scale(input logic [WORD_BITS-1:0] n,
		input logic [5:0] d);
		logic [XW-1:0] ext;
		logic [XW-1:0] p;
		ext = {4'b0000, n};
		unique case (SEL)
			nop_pkg::SEL_BIN: p = ext << 1;
			nop_pkg::SEL_OCT: p = ext << 3;
			nop_pkg::SEL_DEC: p = (ext << 3) + (ext << 1);
			default:          p = ext << 4;
		endcase
		return p + XW'(d);
	endfunction

	logic [XW-1:0]        maxn;
	logic [XW-1:0]        prod_a;
	logic [XW-1:0]        prod_b;
	logic                 bad_a;
	logic                 bad_b;
	logic [WORD_BITS-1:0] acc_a;
	logic                 stop_a;
	logic [POS_BITS-1:0]  spos_a;

	// two chained digit steps
	always_comb begin
		maxn   = ctrl.sr ? SMAX_X : UMAX_X;
		prod_a = scale(acc_q, ctrl.dig_a);
		bad_a  = (ctrl.dig_a >= RADIX) || (prod_a > maxn);
		acc_a  = acc_q;
		stop_a = stop_q;
		spos_a = spos_q;
		if (ctrl.feed_a && !stop_q) begin
			if (bad_a) begin
				stop_a = 1'b1;
				spos_a = pos_a;
			end else begin
				acc_a = prod_a[WORD_BITS-1:0];
			end
		end

		prod_b  = scale(acc_a, ctrl.dig_b);
		bad_b   = (ctrl.dig_b >= RADIX) || (prod_b > maxn);
		acc_nx  = acc_a;
		stop_nx = stop_a;
		spos_nx = spos_a;
		if (ctrl.feed_b && !stop_a) begin
			if (bad_b) begin
				stop_nx = 1'b1;
				spos_nx = pos_b;
			end else begin
				acc_nx = prod_b[WORD_BITS-1:0];
			end
		end
	end

	// lane state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			stop_q <= 1'b0;
			spos_q <= '0;
		end else if (ctrl.adv) begin
			if (ctrl.clr) begin
				acc_q  <= '0;
				stop_q <= 1'b0;
				spos_q <= '0;
			end else begin
				acc_q  <= acc_nx;
				stop_q <= stop_nx;
				spos_q <= spos_nx;
			end
		end
	end

endmodule

// ===== rtl/core/numeric_option_parser.sv =====
// ----------------------------------------------------------------------------
// Numeric option parser
// Parses a numeric option string, one character per word, with sign, 0x
// prefix or b/o/q/d/h radix suffix, into a word with fail flag and position.
// ----------------------------------------------------------------------------
//  channel | dir | word                          | end of item
//  chars   | in  | char_in[7:0], is_last         | is_last = 1
//  result  | out | value, failed, error_pos      | one word per string
//
//  One character per cycle but for the last-character stall below. A
//  character sits in the input register, then the parser and four radix
//  lanes update in one pass. The result is registered: valid rises as the
//  last char leaves. Reset clears all parser state at once; no clearing pass.
//  While a result waits, plain characters keep flowing; a last character
//  waits in the input register until the result register frees up.
// ----------------------------------------------------------------------------
`include "numeric_option_parser_macros.svh"

module numeric_option_parser #(
	parameter int WORD_BITS = 16,
	parameter int POS_BITS  = 8
) (
	input logic        clk,
	input logic        arst_n,
	nop_in_if.sink     chars,
	nop_out_if.source  result
);

	typedef enum logic [2:0] {
		PH_LEAD  = 3'd0,
		PH_START = 3'd1,
		PH_ONE   = 3'd2,
		PH_MORE  = 3'd3,
		PH_HEX   = 3'd4,
		PH_TRAIL = 3'd5,
		PH_JUNK  = 3'd6
	} phase_t;

	// input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       s1_fire;

	// parser state
	phase_t               phase_q;
	logic                 neg_q;
	logic                 sr_q;
	logic [7:0]           held_q;
	logic [POS_BITS-1:0]  hpos_q;
	logic [POS_BITS-1:0]  position_q;
	logic [POS_BITS-1:0]  junk_q;
	nop_pkg::radix_sel_t  rsel_q;

	// result register
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] value_q;
	logic                 failed_q;
	logic [POS_BITS-1:0]  error_pos_q;

	assign s1_fire     = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign chars.ready = !valid_s1 || s1_fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_in;
			last_s1 <= chars.is_last;
		end
	end

	// per-character step
	logic                 ws;
	phase_t               ph1;
	logic                 neg1;
	logic                 sr1;
	logic [7:0]           held1;
	logic [POS_BITS-1:0]  hpos1;
	logic [POS_BITS-1:0]  junk1;
	nop_pkg::radix_sel_t  rsel1;
	nop_pkg::radix_sel_t  rsel2;
	nop_pkg::sfx_t        sfx_q;
	nop_pkg::sfx_t        sfx1;
	logic                 feed_a;
	logic [5:0]           dig_a;
	logic [POS_BITS-1:0]  pos_a;
	logic                 feed_b;
	logic [POS_BITS-1:0]  pos_nx;

	always_comb begin
		ws     = nop_pkg::is_ws(char_s1);
		sfx_q  = nop_pkg::sfx_decode(held_q);
		pos_nx = (position_q == {POS_BITS{1'b1}}) ? position_q : position_q + 1'b1;
		ph1    = phase_q;
		neg1   = neg_q;
		sr1    = sr_q;
		held1  = held_q;
		hpos1  = hpos_q;
		junk1  = junk_q;
		rsel1  = rsel_q;
		feed_a = 1'b0;
		dig_a  = nop_pkg::digit_val(held_q);
		pos_a  = hpos_q;
		unique case (phase_q)
			PH_LEAD: begin
				if (!ws) begin
					if (char_s1 == nop_pkg::CH_MINUS) begin
						neg1 = 1'b1;
						sr1  = 1'b1;
						ph1  = PH_START;
					end else if (char_s1 == nop_pkg::CH_PLUS) begin
						sr1 = 1'b1;
						ph1 = PH_START;
					end else begin
						held1 = char_s1;
						hpos1 = position_q;
						ph1   = PH_ONE;
					end
				end
			end
			PH_START: begin
				if (ws) begin
					rsel1 = nop_pkg::SEL_DEC;
					ph1   = PH_TRAIL;
				end else begin
					held1 = char_s1;
					hpos1 = position_q;
					ph1   = PH_ONE;
				end
			end
			PH_ONE: begin
				if (ws) begin
					feed_a = 1'b1;
					rsel1  = nop_pkg::SEL_DEC;
					ph1    = PH_TRAIL;
				end else if (held_q == nop_pkg::CH_ZERO &&
						(char_s1 | nop_pkg::CASE_BIT) == nop_pkg::CH_LX) begin
					ph1 = PH_HEX;
				end else begin
					feed_a = 1'b1;
					held1  = char_s1;
					hpos1  = position_q;
					ph1    = PH_MORE;
				end
			end
			PH_MORE: begin
				if (ws) begin
					// a held suffix picks the radix, anything else is a digit
					feed_a = !sfx_q.hit;
					rsel1  = sfx_q.hit ? sfx_q.sel : nop_pkg::SEL_DEC;
					ph1    = PH_TRAIL;
				end else begin
					feed_a = 1'b1;
					held1  = char_s1;
					hpos1  = position_q;
				end
			end
			PH_HEX: begin
				if (ws) begin
					rsel1 = nop_pkg::SEL_HEX;
					ph1   = PH_TRAIL;
				end else begin
					feed_a = 1'b1;
					dig_a  = nop_pkg::digit_val(char_s1);
					pos_a  = position_q;
				end
			end
			PH_TRAIL: begin
				if (!ws) begin
					junk1 = position_q;
					ph1   = PH_JUNK;
				end
			end
			PH_JUNK: begin
			end
			default: begin
				ph1 = PH_LEAD;
			end
		endcase

		// last character closes an open word
		sfx1   = nop_pkg::sfx_decode(held1);
		feed_b = 1'b0;
		rsel2  = rsel1;
		if (last_s1) begin
			unique case (ph1)
				PH_START: rsel2 = nop_pkg::SEL_DEC;
				PH_ONE: begin
					feed_b = 1'b1;
					rsel2  = nop_pkg::SEL_DEC;
				end
				PH_MORE: begin
					feed_b = !sfx1.hit;
					rsel2  = sfx1.hit ? sfx1.sel : nop_pkg::SEL_DEC;
				end
				PH_HEX:  rsel2 = nop_pkg::SEL_HEX;
				default: rsel2 = rsel1;
			endcase
		end
	end

	// accumulator lanes
	nop_pkg::lane_ctrl_t  lane_ctrl;
	logic [WORD_BITS-1:0] acc_nx  [nop_pkg::NUM_LANES];
	logic                 stop_nx [nop_pkg::NUM_LANES];
	logic [POS_BITS-1:0]  spos_nx [nop_pkg::NUM_LANES];

	always_comb begin
		lane_ctrl.adv    = s1_fire;
		lane_ctrl.clr    = last_s1;
		lane_ctrl.sr     = sr1;
		lane_ctrl.feed_a = feed_a;
		lane_ctrl.dig_a  = dig_a;
		lane_ctrl.feed_b = feed_b;
		lane_ctrl.dig_b  = nop_pkg::digit_val(held1);
	end

	for (genvar g = 0; g < nop_pkg::NUM_LANES; g++) begin : g_lane
		nop_lane #(
			.WORD_BITS (WORD_BITS),
			.POS_BITS  (POS_BITS),
			.SEL       (nop_pkg::radix_sel_t'(g))
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (lane_ctrl),
			.pos_a   (pos_a),
			.pos_b   (hpos1),
			.acc_nx  (acc_nx[g]),
			.stop_nx (stop_nx[g]),
			.spos_nx (spos_nx[g])
		);
	end

	// result select
	logic [WORD_BITS-1:0] res_mag;
	logic [WORD_BITS-1:0] res_value;
	logic                 res_failed;
	logic [POS_BITS-1:0]  res_pos;

	always_comb begin
		res_mag   = acc_nx[rsel2];
		res_value = neg1 ? ({WORD_BITS{1'b0}} - res_mag) : res_mag;
		if (stop_nx[rsel2]) begin
			res_failed = 1'b1;
			res_pos    = spos_nx[rsel2];
		end else if (ph1 == PH_JUNK) begin
			res_failed = 1'b1;
			res_pos    = junk1;
		end else begin
			res_failed = 1'b0;
			res_pos    = '0;
		end
	end

	// parser state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			neg_q       <= 1'b0;
			sr_q        <= 1'b0;
			held_q      <= '0;
			hpos_q      <= '0;
			position_q  <= '0;
			junk_q      <= '0;
			rsel_q      <= nop_pkg::SEL_DEC;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_fire && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				if (last_s1) begin
					phase_q    <= PH_LEAD;
					neg_q      <= 1'b0;
					sr_q       <= 1'b0;
					held_q     <= '0;
					hpos_q     <= '0;
					position_q <= '0;
					junk_q     <= '0;
					rsel_q     <= nop_pkg::SEL_DEC;
				end else begin
					phase_q    <= ph1;
					neg_q      <= neg1;
					sr_q       <= sr1;
					held_q     <= held1;
					hpos_q     <= hpos1;
					position_q <= pos_nx;
					junk_q     <= junk1;
					rsel_q     <= rsel1;
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			value_q     <= res_value;
			failed_q    <= res_failed;
			error_pos_q <= res_pos;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.value     = value_q;
	assign result.failed    = failed_q;
	assign result.error_pos = error_pos_q;

	// checks
	`NOP_ASSERT_NXT(a_last_gives_result, clk, arst_n, s1_fire && last_s1, out_valid_q)
	`NOP_ASSERT_NXT(a_last_restarts, clk, arst_n, s1_fire && last_s1, phase_q == PH_LEAD && position_q == '0)
	`NOP_ASSERT_IMP(a_ok_pos_zero, clk, arst_n, out_valid_q && !failed_q, error_pos_q == '0)
	`NOP_ASSERT_IMP(a_empty_stage_ready, clk, arst_n, !valid_s1, chars.ready)
	`NOP_ASSERT_IMP(a_lead_no_sign, clk, arst_n, phase_q == PH_LEAD, !neg_q && !sr_q)

endmodule

// ===== dv/numeric_option_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Numeric option parser checker
// Watches the character and result channels, runs a cycle-free parse model
// on every accepted character word, and compares each result word in order.
// ----------------------------------------------------------------------------
module numeric_option_parser_checker #(
	parameter int WORD_BITS = 16,
	parameter int POS_BITS  = 8
) (
	input  logic clk,
	input  logic arst_n,
	nop_in_if    chars,
	nop_out_if   result,
	output int   mismatches,
	output int   outstanding
);

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_START,
		PH_ONE,
		PH_MORE,
		PH_HEX,
		PH_TRAIL,
		PH_JUNK
	} parse_phase_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] value;
		logic                 failed;
		logic [POS_BITS-1:0]  error_pos;
	} parse_result_t;

	localparam longint unsigned WORD_TOP   = (64'd1 << WORD_BITS) - 1;
	localparam longint unsigned SIGNED_TOP = (64'd1 << (WORD_BITS - 1)) - 1;
	localparam logic [POS_BITS-1:0] POS_TOP = '1;
	localparam longint unsigned LANE_RADIX [nop_pkg::NUM_LANES] = '{2, 8, 10, 16};

	// parse state
	parse_phase_t         ph;
	logic                 neg;
	logic                 sgn_range;
	logic [WORD_BITS-1:0] acc [nop_pkg::NUM_LANES];
	logic                 halted [nop_pkg::NUM_LANES];
	logic [POS_BITS-1:0]  halt_pos [nop_pkg::NUM_LANES];
	logic [7:0]           held_c;
	logic [POS_BITS-1:0]  held_p;
	logic [POS_BITS-1:0]  char_idx;
	logic [POS_BITS-1:0]  junk_p;
	nop_pkg::radix_sel_t  sel;

	parse_result_t expected_q [$];

	task automatic report_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		$display("%0t ns: %s mismatch, expected %0h got %0h", $time, what, want, got);
		mismatches++;
	endtask

	function automatic void clear_parse();
		ph        = PH_LEAD;
		neg       = 1'b0;
		sgn_range = 1'b0;
		held_c    = '0;
		held_p    = '0;
		char_idx  = '0;
		junk_p    = '0;
		sel       = nop_pkg::SEL_DEC;
		for (int k = 0; k < nop_pkg::NUM_LANES; k++) begin
			acc[k]      = '0;
			halted[k]   = 1'b0;
			halt_pos[k] = '0;
		end
	endfunction

	function automatic longint unsigned digit_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "A" && c <= "Z") return c - "A" + 10;
		if (c >= "a" && c <= "z") return c - "a" + 10;
		return 99;
	endfunction

	// push one digit into every lane that has not stopped yet
	function automatic void take_digit(input logic [7:0] c, input logic [POS_BITS-1:0] at);
		longint unsigned top, d, r, n, lim;
		top = sgn_range ? SIGNED_TOP : WORD_TOP;
		d   = digit_of(c);
		for (int k = 0; k < nop_pkg::NUM_LANES; k++) begin
			r   = LANE_RADIX[k];
			n   = acc[k];
			lim = top / r;
			if (!halted[k]) begin
				if (d >= r || n > lim || (n == lim && d > top % r)) begin
					halted[k]   = 1'b1;
					halt_pos[k] = at;
				end else begin
					acc[k] = WORD_BITS'(n * r + d);
				end
			end
		end
	endfunction

	// word ends: the held character is either a radix suffix or a digit
	function automatic void close_word();
		logic [7:0] u;
		u   = held_c | 8'h20;
		sel = nop_pkg::SEL_DEC;
		case (ph)
			PH_HEX: sel = nop_pkg::SEL_HEX;
			PH_ONE: take_digit(held_c, held_p);
			PH_MORE: begin
				if (u == "b") sel = nop_pkg::SEL_BIN;
				else if (u == "o" || u == "q") sel = nop_pkg::SEL_OCT;
				else if (u == "d") sel = nop_pkg::SEL_DEC;
				else if (u == "h") sel = nop_pkg::SEL_HEX;
				else take_digit(held_c, held_p);
			end
			default: ;
		endcase
		ph = PH_TRAIL;
	endfunction

	function automatic void hold_char(input logic [7:0] c, input logic [POS_BITS-1:0] at);
		held_c = c;
		held_p = at;
		ph     = PH_ONE;
	endfunction

	function automatic void accept_char(input logic [7:0] c, input logic last);
		logic [POS_BITS-1:0]  at;
		logic                 blank;
		logic [WORD_BITS-1:0] v;
		parse_result_t        r;
		at    = char_idx;
		blank = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
		if (char_idx != POS_TOP) char_idx++;

		case (ph)
			PH_LEAD: begin
				if (!blank) begin
					if (c == "-") begin
						neg       = 1'b1;
						sgn_range = 1'b1;
						ph        = PH_START;
					end else if (c == "+") begin
						sgn_range = 1'b1;
						ph        = PH_START;
					end else begin
						hold_char(c, at);
					end
				end
			end
			PH_START: begin
				if (blank) close_word();
				else hold_char(c, at);
			end
			PH_ONE: begin
				if (blank) begin
					close_word();
				end else if (held_c == "0" && (c | 8'h20) == "x") begin
					ph = PH_HEX;
				end else begin
					take_digit(held_c, held_p);
					hold_char(c, at);
					ph = PH_MORE;
				end
			end
			PH_MORE: begin
				if (blank) begin
					close_word();
				end else begin
					take_digit(held_c, held_p);
					held_c = c;
					held_p = at;
				end
			end
			PH_HEX: begin
				if (blank) close_word();
				else take_digit(c, at);
			end
			PH_TRAIL: begin
				if (!blank) begin
					junk_p = at;
					ph     = PH_JUNK;
				end
			end
			default: ;
		endcase

		if (last) begin
			if (ph inside {PH_START, PH_ONE, PH_MORE, PH_HEX}) close_word();
			v = acc[sel];
			if (neg) v = -v;
			r.value     = v;
			r.failed    = 1'b0;
			r.error_pos = '0;
			if (halted[sel]) begin
				r.failed    = 1'b1;
				r.error_pos = halt_pos[sel];
			end else if (ph == PH_JUNK) begin
				r.failed    = 1'b1;
				r.error_pos = junk_p;
			end
			expected_q.push_back(r);
			clear_parse();
		end
	endfunction

	// model update on accepted characters, compare on accepted results
	always @(posedge clk or negedge arst_n) begin
		parse_result_t want;
		if (!arst_n) begin
			clear_parse();
			expected_q.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (chars.valid && chars.ready) accept_char(chars.char_in, chars.is_last);
			if (result.valid && result.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result word, value", 0, result.value);
				end else begin
					want = expected_q.pop_front();
					if (result.value !== want.value)
						report_mismatch("value", want.value, result.value);
					if (result.failed !== want.failed)
						report_mismatch("failed", want.failed, result.failed);
					if (result.error_pos !== want.error_pos)
						report_mismatch("error_pos", want.error_pos, result.error_pos);
				end
			end
			outstanding <= expected_q.size();
		end
	end

endmodule

// ===== dv/numeric_option_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Numeric option parser testbench
// Sends short hand-picked option strings, then random strings (mostly well
// formed: signs, 0x prefix, radix suffixes, range edges; some noise and junk)
// under three idle patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module numeric_option_parser_tb;

	typedef logic [7:0] text_t [$];

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_CHARS = 383;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// channel drive
	logic       char_valid = 1'b0;
	logic [7:0] char_data  = '0;
	logic       char_last  = 1'b0;
	logic       take_ready = 1'b0;

	int send_idle = 0;
	int recv_idle = 0;
	int sent_chars = 0;
	int quiet_cycles = 0;
	int mismatches;
	int outstanding;

	text_t word_q;

	always #2 clk = ~clk;

	nop_in_if chars ();
	nop_out_if #(.WORD_BITS(16), .POS_BITS(8)) result ();

	assign chars.valid   = char_valid;
	assign chars.char_in = char_data;
	assign chars.is_last = char_last;
	assign result.ready  = take_ready;

	numeric_option_parser #(.WORD_BITS(16), .POS_BITS(8)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.result (result)
	);

	numeric_option_parser_checker #(.WORD_BITS(16), .POS_BITS(8)) parse_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.chars       (chars),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// result side stalls
	always @(posedge clk) begin
		take_ready <= ($urandom_range(99) >= recv_idle);
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((chars.valid && chars.ready) || (result.valid && result.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic logic [7:0] any_case(input logic [7:0] c);
		return $urandom_range(1) ? (c | 8'h20) : c;
	endfunction

	function automatic logic [7:0] digit_char(input int unsigned d);
		if (d < 10) return 8'("0" + d);
		return any_case(8'("A" + d - 10));
	endfunction

	function automatic logic [7:0] blank_char();
		int unsigned p;
		p = $urandom_range(5);
		return (p == 5) ? 8'd32 : 8'(9 + p);
	endfunction

	task automatic load_text(input string s);
		word_q.delete();
		for (int i = 0; i < s.len(); i++) word_q.push_back(s[i]);
	endtask

	// random option string into word_q
	task automatic build_random_option();
		int unsigned     pick, n, radix;
		longint unsigned mag;
		logic            prefixed;
		text_t           body;
		word_q.delete();
		prefixed = 1'b0;

		// raw noise
		if ($urandom_range(99) < 8) begin
			n = $urandom_range(1, 8);
			repeat (n) word_q.push_back(8'($urandom_range(255)));
			return;
		end

		// leading blanks, now and then enough to saturate the index
		if ($urandom_range(199) == 0) n = $urandom_range(250, 270);
		else n = $urandom_range(0, 2);
		repeat (n) word_q.push_back(blank_char());

		pick = $urandom_range(3);
		if (pick == 0) word_q.push_back("-");
		else if (pick == 1) word_q.push_back("+");

		pick = $urandom_range(9);
		if (pick == 0) begin
			// single character word
			word_q.push_back(8'($urandom_range(255)));
		end else if (pick == 1) begin
			// empty word
		end else if (pick == 2) begin
			word_q.push_back("0");
			word_q.push_back(any_case("X"));
			n = $urandom_range(0, 5);
			repeat (n) word_q.push_back(digit_char($urandom_range(15)));
		end else begin
			case ($urandom_range(3))
				0: radix = 2;
				1: radix = 8;
				2: radix = 10;
				default: radix = 16;
			endcase
			case ($urandom_range(7))
				0: mag = 0;
				1: mag = 32767;
				2: mag = 32768;
				3: mag = 65535;
				4: mag = 65536;
				5: mag = $urandom_range(255);
				default: mag = $urandom_range(70000);
			endcase
			do begin
				body.push_front(digit_char(int'(mag % radix)));
				mag = mag / radix;
			end while (mag != 0);
			if ($urandom_range(4) == 0) body.push_front("0");
			if ($urandom_range(9) == 0)
				body[$urandom_range(body.size() - 1)] = 8'($urandom_range(33, 126));
			if (radix == 16 && $urandom_range(1) == 1) begin
				prefixed = 1'b1;
				word_q.push_back("0");
				word_q.push_back(any_case("X"));
			end
			foreach (body[i]) word_q.push_back(body[i]);
			case (radix)
				2: word_q.push_back(any_case("B"));
				8: word_q.push_back(any_case($urandom_range(1) ? "O" : "Q"));
				10: if ($urandom_range(1) == 1) word_q.push_back(any_case("D"));
				default: if (!prefixed) word_q.push_back(any_case("H"));
			endcase
		end

		// trailing blanks and stray text
		n = $urandom_range(0, 2);
		repeat (n) word_q.push_back(blank_char());
		if ($urandom_range(9) == 0) begin
			word_q.push_back(8'($urandom_range(33, 126)));
			if ($urandom_range(1) == 1) word_q.push_back(blank_char());
		end
		if (word_q.size() == 0) word_q.push_back(blank_char());
	endtask

	// one character word, with random idle cycles ahead of it
	task automatic send_char(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < send_idle) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_data  <= c;
		char_last  <= last;
		@(posedge clk);
		while (!chars.ready) @(posedge clk);
	endtask

	task automatic send_text();
		for (int i = 0; i < word_q.size(); i++) send_char(word_q[i], i == word_q.size() - 1);
		sent_chars += word_q.size();
	endtask

	// hold off the sender until every result is back
	task automatic drain();
		char_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		string directed [$] = '{"7", "z", " ", "-", "0x", "65535", "65536", "-32768",
			"0XfFfF", "101B", "17q", "1 x"};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// hand-picked strings
		send_idle = 10;
		recv_idle <= 83;
		foreach (directed[i]) begin
			load_text(directed[i]);
			send_text();
		end

		// random strings under three idle patterns
		sent_chars = 0;
		for (int p = 0; p < 3; p++) begin
			drain();
			case (p)
				0: begin
					send_idle = 10;
					recv_idle <= 83;
				end
				1: begin
					send_idle = 83;
					recv_idle <= 10;
				end
				default: begin
					send_idle = 0;
					recv_idle <= 0;
				end
			endcase
			while (sent_chars < (p + 1) * PHASE_CHARS) begin
				build_random_option();
				send_text();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
